// ----- src/dfr_pkg.sv -----
// ----------------------------------------------------------------------------
// dfr_pkg: shared definitions for the delimited frame receiver
// Buffer sizing, request opcodes, register indexes and field widths.
// ----------------------------------------------------------------------------
package dfr_pkg;

  // frame buffer sizing
  localparam int BUF_DEPTH = 64;
  localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  // field widths
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 6;
  localparam int LEN_W   = 6;
  localparam int TICK_W  = 17;
  localparam int LIMIT_W = 16;

  // stream payload widths (packed fields, padded to whole bytes)
  localparam int IN_BITS  = OP_W + BYTE_W + IDX_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 3 + LEN_W + BYTE_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIMIT_W;

  // request opcodes
  localparam logic [OP_W-1:0] OP_BYTE   = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_STATUS = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_USE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 2'd3;

  // register reset values
  localparam logic [BYTE_W-1:0]  START_RST = 8'd2;
  localparam logic [BYTE_W-1:0]  END_RST   = 8'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd1000;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

endpackage

// ----- src/delimited_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// delimited_frame_receiver_core: start/end delimited serial frame receiver
// The result is registered and turns valid in the cycle after request accept.
// Throughput: one request per cycle; the result register and the buffer
// read port are the only stages, so a stall on the result side holds input.
// Reset: synchronous active-low rst_n clears control state, registers take
// their defaults and buffer valid bits clear so every slot reads as zero.
// ----------------------------------------------------------------------------
module delimited_frame_receiver_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // opcode[1:0], rx_byte[9:2], read_index[15:10]
  input  logic [dfr_pkg::IN_W-1:0]        in_tdata,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // frame_ready[0], frame_timed_out[1], receiving[2], frame_length[8:3],
  // read_data[16:9], zero pad above
  output logic [dfr_pkg::OUT_W-1:0]       out_tdata
);

  localparam int AW = dfr_pkg::BUF_AW;
  localparam logic [AW-1:0] LAST_SLOT = AW'(dfr_pkg::BUF_DEPTH - 1);

  // configuration registers
  logic                          use_start_r;
  logic [dfr_pkg::BYTE_W-1:0]    start_byte_r;
  logic [dfr_pkg::BYTE_W-1:0]    end_byte_r;
  logic [dfr_pkg::LIMIT_W-1:0]   limit_r;

  // receiver state
  logic [AW-1:0]                 wp_r, wp_nxt;
  logic                          in_frame_r, in_frame_nxt;
  logic                          ready_r, ready_nxt;
  logic                          tout_r, tout_nxt;
  logic [dfr_pkg::TICK_W-1:0]    ticks_r, ticks_nxt;
  logic [dfr_pkg::LEN_W-1:0]     len_r, len_nxt;

  // buffer
  logic [dfr_pkg::BYTE_W-1:0]    mem [dfr_pkg::BUF_DEPTH];
  logic [dfr_pkg::BUF_DEPTH-1:0] vld_r;
  logic [dfr_pkg::BYTE_W-1:0]    rd_q_r;
  logic                          rd_en_r;

  // result register
  logic                          out_valid_r;
  logic                          o_ready_r, o_tout_r, o_recv_r;
  logic [dfr_pkg::LEN_W-1:0]     o_len_r;

  // request fields
  logic [dfr_pkg::OP_W-1:0]      op;
  logic [dfr_pkg::BYTE_W-1:0]    rx_byte;
  logic [dfr_pkg::IDX_W-1:0]     read_index;
  logic                          accept;

  // step intermediates
  logic                          t_fire;
  logic [dfr_pkg::TICK_W-1:0]    ticks_inc;
  logic                          inf_a;
  logic [AW-1:0]                 wp_a;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [31:0]                   idx_ext;
  logic                          rd_hit;
  logic [AW-1:0]                 rd_addr;

  assign op         = in_tdata[dfr_pkg::OP_W-1:0];
  assign rx_byte    = in_tdata[dfr_pkg::OP_W +: dfr_pkg::BYTE_W];
  assign read_index = in_tdata[dfr_pkg::OP_W + dfr_pkg::BYTE_W +: dfr_pkg::IDX_W];

  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;

  // buffer read address, out-of-range index reads zero
  assign idx_ext = 32'(read_index);
  assign rd_hit  = idx_ext < dfr_pkg::BUF_DEPTH;
  assign rd_addr = idx_ext[AW-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_start_r  <= 1'b0;
      start_byte_r <= dfr_pkg::START_RST;
      end_byte_r   <= dfr_pkg::END_RST;
      limit_r      <= dfr_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfr_pkg::REG_USE_START: use_start_r  <= cfg_wdata[0];
        dfr_pkg::REG_START:     start_byte_r <= cfg_wdata[dfr_pkg::BYTE_W-1:0];
        dfr_pkg::REG_END:       end_byte_r   <= cfg_wdata[dfr_pkg::BYTE_W-1:0];
        dfr_pkg::REG_LIMIT:     limit_r      <= cfg_wdata;
        default:                ;
      endcase
    end
  end

  // next receiver state for one request
  always_comb begin
    wp_nxt       = wp_r;
    in_frame_nxt = in_frame_r;
    ready_nxt    = ready_r;
    tout_nxt     = tout_r;
    ticks_nxt    = ticks_r;
    len_nxt      = len_r;
    wr_en        = 1'b0;
    wr_addr      = wp_r;
    t_fire       = 1'b0;
    inf_a        = in_frame_r;
    wp_a         = wp_r;
    ticks_inc    = (ticks_r == dfr_pkg::TICK_MAX) ? ticks_r : ticks_r + 1'b1;

    unique case (op)
      dfr_pkg::OP_BYTE: begin
        // timeout check ahead of the byte
        t_fire = in_frame_r & ~ready_r &
                 (ticks_r > dfr_pkg::TICK_W'(limit_r));
        if (t_fire) begin
          len_nxt  = dfr_pkg::LEN_W'(32'(wp_r));
          tout_nxt = 1'b1;
        end
        inf_a = in_frame_r & ~t_fire;
        wp_a  = t_fire ? '0 : wp_r;
        wp_nxt       = wp_a;
        in_frame_nxt = inf_a;
        // free-running mode opens a frame on any byte
        if (!use_start_r && !inf_a) begin
          inf_a     = 1'b1;
          ticks_nxt = '0;
        end
        if (inf_a && rx_byte != end_byte_r) begin
          // store and advance, holding at the last slot
          wr_en        = 1'b1;
          wr_addr      = wp_a;
          in_frame_nxt = 1'b1;
          wp_nxt       = (wp_a == LAST_SLOT) ? wp_a : wp_a + 1'b1;
        end else if (inf_a) begin
          // end byte completes the frame
          len_nxt      = dfr_pkg::LEN_W'(32'(wp_a));
          wp_nxt       = '0;
          in_frame_nxt = 1'b0;
          tout_nxt     = 1'b0;
          ready_nxt    = 1'b1;
        end else if (use_start_r && rx_byte == start_byte_r) begin
          in_frame_nxt = 1'b1;
          ticks_nxt    = '0;
        end
      end
      dfr_pkg::OP_TICK: begin
        // count then check
        ticks_nxt = ticks_inc;
        t_fire = in_frame_r & ~ready_r &
                 (ticks_inc > dfr_pkg::TICK_W'(limit_r));
        if (t_fire) begin
          len_nxt      = dfr_pkg::LEN_W'(32'(wp_r));
          wp_nxt       = '0;
          in_frame_nxt = 1'b0;
          tout_nxt     = 1'b1;
        end
      end
      dfr_pkg::OP_STATUS: begin
        ready_nxt = 1'b0;
        tout_nxt  = 1'b0;
      end
      dfr_pkg::OP_READ: ;
      default: ;
    endcase
  end

  // receiver state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      in_frame_r <= 1'b0;
      ready_r    <= 1'b0;
      tout_r     <= 1'b0;
      ticks_r    <= '0;
      len_r      <= '0;
    end else if (accept) begin
      wp_r       <= wp_nxt;
      in_frame_r <= in_frame_nxt;
      ready_r    <= ready_nxt;
      tout_r     <= tout_nxt;
      ticks_r    <= ticks_nxt;
      len_r      <= len_nxt;
    end
  end

  // buffer valid bits, unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (accept && wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // buffer write port
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= rx_byte;
    end
  end

  // buffer read port, registered
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      // status read shows flags before clearing
      o_ready_r <= (op == dfr_pkg::OP_STATUS) ? ready_r : ready_nxt;
      o_tout_r  <= (op == dfr_pkg::OP_STATUS) ? tout_r  : tout_nxt;
      o_recv_r  <= in_frame_nxt;
      o_len_r   <= len_nxt;
      rd_en_r   <= (op == dfr_pkg::OP_READ) & rd_hit & vld_r[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = dfr_pkg::OUT_W'({(rd_en_r ? rd_q_r : {dfr_pkg::BYTE_W{1'b0}}),
                                       o_len_r, o_recv_r, o_tout_r, o_ready_r});

endmodule

// ----- src/dfr_checker.sv -----
// ----------------------------------------------------------------------------
// dfr_checker: port-level checks for the delimited frame receiver
// Watches the request and result streams of the top level.
// ----------------------------------------------------------------------------
module dfr_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [dfr_pkg::OUT_W-1:0]    out_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every accepted request yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted request produced no result");

  // stalled result blocks new requests
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken while result stalled");

  // completed and timed-out never both pending
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("ready and timed-out both set");

endmodule

bind delimited_frame_receiver_core dfr_checker u_dfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- test/tb_delimited_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// tb_delimited_frame_receiver_core: self-checking bench for the frame receiver
// A directed table covers reset values, delimiter and timeout corner cases.
// Random phases follow, each with its own register setting and traffic
// pattern.
// A request-level shadow of the receiver predicts every result.
// ----------------------------------------------------------------------------
module tb_delimited_frame_receiver_core;

  // result fields, highest bits first in out_tdata
  typedef struct packed {
    logic [dfr_pkg::BYTE_W-1:0] read_data;
    logic [dfr_pkg::LEN_W-1:0]  frame_length;
    logic                       receiving;
    logic                       timed_out;
    logic                       ready;
  } rx_status_t;

  // one directed step: a request or a register write
  typedef struct packed {
    logic                           is_cfg;
    logic [dfr_pkg::OP_W-1:0]       code;
    logic [dfr_pkg::CFG_DATA_W-1:0] value;
    logic [dfr_pkg::IDX_W-1:0]      idx;
    logic                           typed;
    rx_status_t                     status;
  } dir_row_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int LONG_HOLD = 300;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           cfg_we     = 1'b0;
  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [dfr_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  // opcode[1:0], rx_byte[9:2], read_index[15:10]
  logic [dfr_pkg::IN_W-1:0]       in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // frame_ready[0], frame_timed_out[1], receiving[2], frame_length[8:3],
  // read_data[16:9], zero pad above
  logic [dfr_pkg::OUT_W-1:0]      out_tdata;

  // shadow of the receiver state and registers
  logic [dfr_pkg::BYTE_W-1:0]  sh_buf [dfr_pkg::BUF_DEPTH];
  logic [dfr_pkg::BUF_AW-1:0]  sh_wpos;
  logic                        sh_in_frame;
  logic                        sh_ready;
  logic                        sh_tout;
  logic [dfr_pkg::TICK_W-1:0]  sh_ticks;
  logic [dfr_pkg::LEN_W-1:0]   sh_len;
  logic                        sh_use_start;
  logic [dfr_pkg::BYTE_W-1:0]  sh_start;
  logic [dfr_pkg::BYTE_W-1:0]  sh_end;
  logic [dfr_pkg::LIMIT_W-1:0] sh_limit;

  rx_status_t rx_status_q [$];
  dir_row_t   dir_tab [$];
  int         sent_items     = 0;
  int         mismatch_count = 0;
  int         send_pct       = 0;
  int         stall_pct      = 0;
  logic       hold_kick      = 1'b0;
  logic       hold_seen      = 1'b0;
  int         hold_left      = 0;
  rx_status_t mon_got;
  rx_status_t mon_want;

  delimited_frame_receiver_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // close an open frame once the tick budget is spent
  function automatic void end_on_timeout();
    if (sh_ticks > {1'b0, sh_limit} && !sh_ready && sh_in_frame) begin
      sh_len      = dfr_pkg::LEN_W'(sh_wpos);
      sh_wpos     = '0;
      sh_in_frame = 1'b0;
      sh_tout     = 1'b1;
    end
  endfunction

  // advance the shadow by one request and return the status it reports
  function automatic rx_status_t step_receiver(logic [dfr_pkg::OP_W-1:0] op,
                                               logic [dfr_pkg::BYTE_W-1:0] b,
                                               logic [dfr_pkg::IDX_W-1:0] idx);
    rx_status_t r;
    r = '0;
    case (op)
      dfr_pkg::OP_BYTE: begin
        end_on_timeout();
        if (!sh_use_start && !sh_in_frame) begin
          sh_in_frame = 1'b1;
          sh_ticks    = '0;
        end
        if (sh_in_frame && b != sh_end) begin
          sh_buf[sh_wpos] = b;
          if (sh_wpos != dfr_pkg::BUF_AW'(dfr_pkg::BUF_DEPTH - 1))
            sh_wpos = sh_wpos + 1'b1;
        end else if (sh_in_frame) begin
          sh_len      = dfr_pkg::LEN_W'(sh_wpos);
          sh_wpos     = '0;
          sh_in_frame = 1'b0;
          sh_tout     = 1'b0;
          sh_ready    = 1'b1;
        end else if (sh_use_start && b == sh_start) begin
          sh_in_frame = 1'b1;
          sh_ticks    = '0;
        end
      end
      dfr_pkg::OP_TICK: begin
        if (sh_ticks != dfr_pkg::TICK_MAX) sh_ticks = sh_ticks + 1'b1;
        end_on_timeout();
      end
      dfr_pkg::OP_READ: begin
        r.read_data = sh_buf[idx];
      end
      default: ;
    endcase
    r.ready        = sh_ready;
    r.timed_out    = sh_tout;
    r.receiving    = sh_in_frame;
    r.frame_length = sh_len;
    if (op == dfr_pkg::OP_STATUS) begin
      sh_ready = 1'b0;
      sh_tout  = 1'b0;
    end
    return r;
  endfunction

  function automatic rx_status_t rx_status(logic rdy, logic tout, logic recv,
                                           logic [dfr_pkg::LEN_W-1:0] len,
                                           logic [dfr_pkg::BYTE_W-1:0] data);
    rx_status_t s;
    s.ready        = rdy;
    s.timed_out    = tout;
    s.receiving    = recv;
    s.frame_length = len;
    s.read_data    = data;
    return s;
  endfunction

  function automatic dir_row_t req_row(logic [dfr_pkg::OP_W-1:0] op,
                                       logic [dfr_pkg::BYTE_W-1:0] b,
                                       logic [dfr_pkg::IDX_W-1:0] idx);
    dir_row_t row;
    row = '0;
    row.code  = op;
    row.value = dfr_pkg::CFG_DATA_W'(b);
    row.idx   = idx;
    return row;
  endfunction

  function automatic dir_row_t req_chk(logic [dfr_pkg::OP_W-1:0] op,
                                       logic [dfr_pkg::BYTE_W-1:0] b,
                                       logic [dfr_pkg::IDX_W-1:0] idx,
                                       rx_status_t status);
    dir_row_t row;
    row        = req_row(op, b, idx);
    row.typed  = 1'b1;
    row.status = status;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [dfr_pkg::CFG_IDX_W-1:0] reg_idx,
                                       logic [dfr_pkg::CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.code   = reg_idx;
    row.value  = val;
    return row;
  endfunction

  // offer one request, wait for the handshake, queue its status
  task automatic send_req(input logic [dfr_pkg::OP_W-1:0] op,
                          input logic [dfr_pkg::BYTE_W-1:0] b,
                          input logic [dfr_pkg::IDX_W-1:0] idx, input logic typed = 1'b0,
                          input rx_status_t status = '0);
    rx_status_t pred;
    while ($urandom_range(99) < send_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= dfr_pkg::IN_W'({idx, b, op});
    do @(posedge clk); while (!in_tready);
    pred = step_receiver(op, b, idx);
    rx_status_q.push_back(typed ? status : pred);
    sent_items++;
  endtask

  // stop offering until every queued status has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (rx_status_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dfr_pkg::CFG_IDX_W-1:0] reg_idx,
                           input logic [dfr_pkg::CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= reg_idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (reg_idx)
      dfr_pkg::REG_USE_START: sh_use_start = val[0];
      dfr_pkg::REG_START:     sh_start     = val[dfr_pkg::BYTE_W-1:0];
      dfr_pkg::REG_END:       sh_end       = val[dfr_pkg::BYTE_W-1:0];
      dfr_pkg::REG_LIMIT:     sh_limit     = val[dfr_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // one register setting and idle pattern, then random traffic
  task automatic run_phase(input logic use_start, input logic [dfr_pkg::BYTE_W-1:0] sb,
                           input logic [dfr_pkg::BYTE_W-1:0] eb,
                           input logic [dfr_pkg::LIMIT_W-1:0] lim,
                           input idle_mode_t mode, input int n_items, input bit long_hold);
    int first;
    int roll;
    int n;
    logic [dfr_pkg::BYTE_W-1:0] d;
    write_reg(dfr_pkg::REG_USE_START, dfr_pkg::CFG_DATA_W'(use_start));
    write_reg(dfr_pkg::REG_START, dfr_pkg::CFG_DATA_W'(sb));
    write_reg(dfr_pkg::REG_END, dfr_pkg::CFG_DATA_W'(eb));
    write_reg(dfr_pkg::REG_LIMIT, dfr_pkg::CFG_DATA_W'(lim));
    case (mode)
      IDLE_SEND: begin send_pct = 63; stall_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  stall_pct = 63; end
      IDLE_BOTH: begin send_pct = 17; stall_pct = 17; end
      default:   begin send_pct = 0;  stall_pct = 0;  end
    endcase
    if (long_hold) hold_kick = ~hold_kick;
    first = sent_items;
    while (sent_items - first < n_items) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        // frame with random content and scattered ticks, mostly closed by the end byte
        n = ($urandom_range(9) == 0) ? $urandom_range(80, 60) : $urandom_range(12);
        if (sh_use_start)
          send_req(dfr_pkg::OP_BYTE, sh_start, dfr_pkg::IDX_W'($urandom));
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(3) == 0)
            send_req(dfr_pkg::OP_TICK, dfr_pkg::BYTE_W'($urandom),
                     dfr_pkg::IDX_W'($urandom));
          d = dfr_pkg::BYTE_W'($urandom);
          if (d == sh_end) d = ~d;
          send_req(dfr_pkg::OP_BYTE, d, dfr_pkg::IDX_W'($urandom));
        end
        if ($urandom_range(7) != 0)
          send_req(dfr_pkg::OP_BYTE, sh_end, dfr_pkg::IDX_W'($urandom));
        repeat ($urandom_range(3))
          send_req(dfr_pkg::OP_READ, dfr_pkg::BYTE_W'($urandom),
                   dfr_pkg::IDX_W'($urandom_range((n > 63) ? 63 : n)));
        if ($urandom_range(1) == 0)
          send_req(dfr_pkg::OP_STATUS, dfr_pkg::BYTE_W'($urandom),
                   dfr_pkg::IDX_W'($urandom));
      end else if (roll < 90) begin
        // noise: any request with any content
        repeat ($urandom_range(6, 1))
          send_req(dfr_pkg::OP_W'($urandom), dfr_pkg::BYTE_W'($urandom),
                   dfr_pkg::IDX_W'($urandom));
      end else if (roll < 97) begin
        // burst of ticks to push open frames past the limit
        repeat ($urandom_range(24, 1))
          send_req(dfr_pkg::OP_TICK, dfr_pkg::BYTE_W'($urandom),
                   dfr_pkg::IDX_W'($urandom));
      end else begin
        wait_drained();
      end
    end
  endtask

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen  <= hold_kick;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each returned status with the oldest queued one
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      mon_got = out_tdata[dfr_pkg::OUT_BITS-1:0];
      if (rx_status_q.size() == 0) begin
        $display("%0t: status with no request pending, expected none, actual %0h",
                 $time, mon_got);
        mismatch_count++;
      end else begin
        mon_want = rx_status_q.pop_front();
        check_field("frame_ready", 32'(mon_want.ready), 32'(mon_got.ready));
        check_field("frame_timed_out", 32'(mon_want.timed_out), 32'(mon_got.timed_out));
        check_field("receiving", 32'(mon_want.receiving), 32'(mon_got.receiving));
        check_field("frame_length", 32'(mon_want.frame_length),
                    32'(mon_got.frame_length));
        check_field("read_data", 32'(mon_want.read_data), 32'(mon_got.read_data));
      end
    end
  end

  initial begin
    // reset values, delimiters outside frames, timeouts before a byte
    dir_tab.push_back(req_chk(dfr_pkg::OP_STATUS, 8'h00, 6'd0,
                              rx_status(1'b0, 1'b0, 1'b0, 6'd0, 8'h00)));
    dir_tab.push_back(req_chk(dfr_pkg::OP_READ, 8'h00, 6'd0,
                              rx_status(1'b0, 1'b0, 1'b0, 6'd0, 8'h00)));
    dir_tab.push_back(req_chk(dfr_pkg::OP_READ, 8'hFF, 6'd63,
                              rx_status(1'b0, 1'b0, 1'b0, 6'd0, 8'h00)));
    dir_tab.push_back(req_row(dfr_pkg::OP_BYTE, 8'h00, 6'd63));
    dir_tab.push_back(req_row(dfr_pkg::OP_BYTE, 8'hFF, 6'd0));
    dir_tab.push_back(req_chk(dfr_pkg::OP_BYTE, dfr_pkg::END_RST, 6'd0,
                              rx_status(1'b1, 1'b0, 1'b0, 6'd2, 8'h00)));
    dir_tab.push_back(req_chk(dfr_pkg::OP_READ, 8'h00, 6'd1,
                              rx_status(1'b1, 1'b0, 1'b0, 6'd2, 8'hFF)));
    // end byte with no frame open and no start mode: empty frame
    dir_tab.push_back(req_row(dfr_pkg::OP_BYTE, dfr_pkg::END_RST, 6'd0));
    dir_tab.push_back(req_chk(dfr_pkg::OP_STATUS, 8'h00, 6'd0,
                              rx_status(1'b1, 1'b0, 1'b0, 6'd0, 8'h00)));
    dir_tab.push_back(req_chk(dfr_pkg::OP_STATUS, 8'h00, 6'd0,
                              rx_status(1'b0, 1'b0, 1'b0, 6'd0, 8'h00)));
    // zero limit: first tick in a frame times out
    dir_tab.push_back(cfg_row(dfr_pkg::REG_LIMIT, 16'd0));
    dir_tab.push_back(req_row(dfr_pkg::OP_BYTE, 8'h55, 6'd0));
    dir_tab.push_back(req_chk(dfr_pkg::OP_TICK, 8'h00, 6'd0,
                              rx_status(1'b0, 1'b1, 1'b0, 6'd1, 8'h00)));
    dir_tab.push_back(req_chk(dfr_pkg::OP_STATUS, 8'h00, 6'd0,
                              rx_status(1'b0, 1'b1, 1'b0, 6'd1, 8'h00)));
    // start mode with extreme delimiters
    dir_tab.push_back(cfg_row(dfr_pkg::REG_USE_START, 16'd1));
    dir_tab.push_back(cfg_row(dfr_pkg::REG_START, 16'h00FF));
    dir_tab.push_back(cfg_row(dfr_pkg::REG_END, 16'h0000));
    dir_tab.push_back(cfg_row(dfr_pkg::REG_LIMIT, 16'd2));
    dir_tab.push_back(req_row(dfr_pkg::OP_BYTE, 8'h00, 6'd0));
    dir_tab.push_back(req_row(dfr_pkg::OP_BYTE, 8'hFF, 6'd0));
    dir_tab.push_back(req_row(dfr_pkg::OP_TICK, 8'h00, 6'd0));
    // start byte inside a frame is plain data
    dir_tab.push_back(req_row(dfr_pkg::OP_BYTE, 8'hFF, 6'd0));
    dir_tab.push_back(req_chk(dfr_pkg::OP_BYTE, 8'h00, 6'd0,
                              rx_status(1'b1, 1'b0, 1'b0, 6'd1, 8'h00)));
    // pending frame holds off the timeout until status is read
    dir_tab.push_back(req_row(dfr_pkg::OP_BYTE, 8'hFF, 6'd0));
    dir_tab.push_back(req_row(dfr_pkg::OP_TICK, 8'h00, 6'd0));
    dir_tab.push_back(req_row(dfr_pkg::OP_TICK, 8'h00, 6'd0));
    dir_tab.push_back(req_row(dfr_pkg::OP_TICK, 8'h00, 6'd0));
    dir_tab.push_back(req_row(dfr_pkg::OP_STATUS, 8'h00, 6'd0));
    dir_tab.push_back(req_chk(dfr_pkg::OP_BYTE, 8'h01, 6'd0,
                              rx_status(1'b0, 1'b1, 1'b0, 6'd0, 8'h00)));
    dir_tab.push_back(req_row(dfr_pkg::OP_READ, 8'h00, 6'd0));

    // shadow reset
    foreach (sh_buf[i]) sh_buf[i] = '0;
    sh_wpos      = '0;
    sh_in_frame  = 1'b0;
    sh_ready     = 1'b0;
    sh_tout      = 1'b0;
    sh_ticks     = '0;
    sh_len       = '0;
    sh_use_start = 1'b0;
    sh_start     = dfr_pkg::START_RST;
    sh_end       = dfr_pkg::END_RST;
    sh_limit     = dfr_pkg::LIMIT_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].code, dir_tab[i].value);
      else send_req(dir_tab[i].code, dir_tab[i].value[dfr_pkg::BYTE_W-1:0],
                    dir_tab[i].idx, dir_tab[i].typed, dir_tab[i].status);
    end

    // random phases
    run_phase(1'b0, 8'h02, 8'h0A, 16'd5,     IDLE_NONE, 230, 1'b0);
    run_phase(1'b1, 8'h7E, 8'h7F, 16'hFFFF,  IDLE_SEND, 230, 1'b0);
    run_phase(1'b1, 8'h00, 8'hFF, 16'd8,     IDLE_RECV, 230, 1'b1);
    run_phase(1'b0, 8'hA5, 8'h00, 16'd0,     IDLE_BOTH, 230, 1'b0);
    run_phase(1'b1, 8'hFF, 8'h00, 16'd12,    IDLE_NONE, 230, 1'b0);
    run_phase(1'b0, 8'h33, 8'hFF, 16'd20,    IDLE_SEND, 230, 1'b0);

    // drain and report
    in_tvalid <= 1'b0;
    while (rx_status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && rx_status_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
